[hw/rtl/tpcc_pkg.sv]
package tpcc_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned TimeW    = 22;
  localparam int unsigned StampW   = 32;

  localparam logic [1:0] MODE_MENU  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_OVER  = 2'd2;
  localparam logic [1:0] MODE_PAUSE = 2'd3;

  localparam logic [1:0] PLAYER_NONE   = 2'd0;
  localparam logic [1:0] PLAYER_FIRST  = 2'd1;
  localparam logic [1:0] PLAYER_SECOND = 2'd2;

  localparam logic [2:0] CHOICE_LAST = 3'd4;

  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_SHORT_MAX  = 2'd1;
  localparam logic [1:0] REG_SHORT_MIN  = 2'd2;

  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [CfgW-1:0] SHORT_MAX_RST  = 16'd2000;
  localparam logic [CfgW-1:0] SHORT_MIN_RST  = 16'd50;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] short_press_max_ms;
    logic [CfgW-1:0] short_press_min_ms;
  } cfg_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic              right_button;
    logic              middle_button;
    logic              left_button;
    logic [StampW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       pad;
    logic             reset_pulse;
    logic [1:0]       winner;
    logic [2:0]       menu_choice;
    logic [TimeW-1:0] second_time_ms;
    logic [TimeW-1:0] first_time_ms;
    logic [1:0]       active_player;
    logic [1:0]       clock_mode;
  } out_item_t;

  function automatic logic [TimeW-1:0] preset_ms(input logic [2:0] choice);
    logic [TimeW-1:0] val;
    case (choice)
      3'd0:    val = 22'd60000;
      3'd1:    val = 22'd180000;
      3'd2:    val = 22'd600000;
      3'd3:    val = 22'd1800000;
      3'd4:    val = 22'd3599999;
      default: val = 22'd60000;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/two_player_countdown_clock_unit.sv]
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  s_axis_tdata_i (40 bits)
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  m_axis_tdata_o (56 bits)
// apb       in         psel/penable/pready              paddr, pwdata, prdata
//
// One word is accepted per cycle while the result is not stalled; its result
// leaves after passing the input register and then the result register.
// The clock state is updated in the same cycle the result register loads.
// Reset clears the clock state and the valid flags of both register stages and
// loads the configuration defaults.
// A stalled result holds in the result register while the input register
// still takes one more word.
module two_player_countdown_clock_unit import tpcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // now_ms[31:0], left_button[32], middle_button[33], right_button[34], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // clock_mode[1:0], active_player[3:2], first_time_ms[25:4],
  // second_time_ms[47:26], menu_choice[50:48], winner[52:51],
  // reset_pulse[53], zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t out_q;
  out_item_t result;
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      in_fire, step;

  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_fire || (in_valid_q && !step);
  assign out_valid_d     = step || (out_valid_q && !m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  tpcc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpcc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= s_axis_tdata_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

endmodule

[hw/rtl/tpcc_apb_regs.sv]
module tpcc_apb_regs import tpcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms      <= LONG_PRESS_RST;
      cfg_q.short_press_max_ms <= SHORT_MAX_RST;
      cfg_q.short_press_min_ms <= SHORT_MIN_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LONG_PRESS: cfg_q.long_press_ms      <= pwdata[CfgW-1:0];
        REG_SHORT_MAX:  cfg_q.short_press_max_ms <= pwdata[CfgW-1:0];
        REG_SHORT_MIN:  cfg_q.short_press_min_ms <= pwdata[CfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_ms};
      REG_SHORT_MAX:  prdata = {16'd0, cfg_q.short_press_max_ms};
      REG_SHORT_MIN:  prdata = {16'd0, cfg_q.short_press_min_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

[hw/rtl/tpcc_core.sv]
module tpcc_core import tpcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  typedef enum logic [1:0] {
    ST_MENU  = MODE_MENU,
    ST_RUN   = MODE_RUN,
    ST_OVER  = MODE_OVER,
    ST_PAUSE = MODE_PAUSE
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [1:0]        player_q, player_d;
  logic [TimeW-1:0]  first_q, first_d;
  logic [TimeW-1:0]  second_q, second_d;
  logic [StampW-1:0] last_q, last_d;
  logic [2:0]        choice_q, choice_d;
  logic              held_q, held_d;
  logic [StampW-1:0] start_q, start_d;
  logic              pend_q, pend_d;
  logic              await_q, await_d;
  logic              prev_left_q, prev_right_q;

  logic [StampW-1:0] now;
  logic [StampW-1:0] hold_ms;
  logic [StampW-1:0] delta;
  logic [TimeW-1:0]  run_time;
  logic              run_left;
  logic [TimeW-1:0]  run_next;
  logic              press1, press2;
  logic              pulse;
  logic [2:0]        ch;

  assign now     = item_i.now_ms;
  assign hold_ms = now - start_q;
  assign press1  = item_i.left_button && !prev_left_q;
  assign press2  = item_i.right_button && !prev_right_q;
  assign delta   = now - last_q;

  always_comb begin
    mode_d   = mode_q;
    player_d = player_q;
    first_d  = first_q;
    second_d = second_q;
    last_d   = last_q;
    choice_d = choice_q;
    held_d   = held_q;
    start_d  = start_q;
    pend_d   = pend_q;
    await_d  = await_q;
    pulse    = 1'b0;
    ch       = choice_q;
    run_time = '0;
    run_left = 1'b0;
    run_next = '0;

    if (item_i.middle_button) begin
      if (await_q) begin
      end else if (!held_q) begin
        held_d  = 1'b1;
        start_d = now;
      end else if (hold_ms >= {16'd0, cfg_i.long_press_ms}) begin
        mode_d   = ST_MENU;
        player_d = PLAYER_NONE;
        held_d   = 1'b0;
        pend_d   = 1'b0;
        await_d  = 1'b1;
        pulse    = 1'b1;
      end
    end else begin
      await_d = 1'b0;
      if (held_q) begin
        if ((hold_ms < {16'd0, cfg_i.short_press_max_ms}) &&
            (hold_ms > {16'd0, cfg_i.short_press_min_ms})) begin
          pend_d = 1'b1;
        end
        held_d = 1'b0;
      end
    end

    case (mode_d)
      ST_MENU: begin
        ch = (choice_q > CHOICE_LAST) ? 3'd0 : choice_q;
        if (press1) begin
          ch = (ch == 3'd0) ? CHOICE_LAST : ch - 3'd1;
        end
        if (press2) begin
          ch = (ch == CHOICE_LAST) ? 3'd0 : ch + 3'd1;
        end
        choice_d = ch;
        if (pend_d) begin
          pend_d   = 1'b0;
          first_d  = preset_ms(ch);
          second_d = preset_ms(ch);
          mode_d   = ST_PAUSE;
          last_d   = now;
        end
      end
      ST_RUN: begin
        if (pend_d) begin
          pend_d = 1'b0;
          mode_d = ST_PAUSE;
        end else begin
          if (press1) begin
            player_d = PLAYER_SECOND;
          end
          if (press2) begin
            player_d = PLAYER_FIRST;
          end
          last_d   = now;
          run_time = (player_d == PLAYER_FIRST) ? first_q : second_q;
          run_left = {10'd0, run_time} > delta;
          run_next = run_left ? (run_time - delta[TimeW-1:0]) : '0;
          if (player_d == PLAYER_FIRST) begin
            first_d = run_next;
            if (!run_left) begin
              mode_d = ST_OVER;
            end
          end else if (player_d == PLAYER_SECOND) begin
            second_d = run_next;
            if (!run_left) begin
              mode_d = ST_OVER;
            end
          end
        end
      end
      ST_OVER: begin
        if (pend_d) begin
          mode_d   = ST_MENU;
          player_d = PLAYER_NONE;
          held_d   = 1'b0;
          pend_d   = 1'b0;
        end
      end
      default: begin
        if (pend_d) begin
          pend_d = 1'b0;
          mode_d = ST_RUN;
          last_d = now;
        end
        if (press1) begin
          player_d = PLAYER_SECOND;
          mode_d   = ST_RUN;
          last_d   = now;
        end
        if (press2) begin
          player_d = PLAYER_FIRST;
          mode_d   = ST_RUN;
          last_d   = now;
        end
      end
    endcase
  end

  always_comb begin
    result_o                = '0;
    result_o.clock_mode     = mode_d;
    result_o.active_player  = player_d;
    result_o.first_time_ms  = first_d;
    result_o.second_time_ms = second_d;
    result_o.menu_choice    = choice_d;
    result_o.reset_pulse    = pulse;
    if (mode_d == ST_OVER) begin
      result_o.winner = (first_d == '0) ? PLAYER_SECOND : PLAYER_FIRST;
    end else begin
      result_o.winner = PLAYER_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ST_MENU;
      player_q     <= PLAYER_NONE;
      first_q      <= '0;
      second_q     <= '0;
      last_q       <= '0;
      choice_q     <= '0;
      held_q       <= 1'b0;
      start_q      <= '0;
      pend_q       <= 1'b0;
      await_q      <= 1'b0;
      prev_left_q  <= 1'b0;
      prev_right_q <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      player_q     <= player_d;
      first_q      <= first_d;
      second_q     <= second_d;
      last_q       <= last_d;
      choice_q     <= choice_d;
      held_q       <= held_d;
      start_q      <= start_d;
      pend_q       <= pend_d;
      await_q      <= await_d;
      prev_left_q  <= item_i.left_button;
      prev_right_q <= item_i.right_button;
    end
  end

endmodule

[hw/rtl/tpcc_checker.sv]
module tpcc_checker import tpcc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0] mode;
  logic [1:0] player;
  logic [1:0] winner;

  assign mode   = m_axis_tdata_o[1:0];
  assign player = m_axis_tdata_o[3:2];
  assign winner = m_axis_tdata_o[52:51];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_winner_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((winner != PLAYER_NONE) == (mode == MODE_OVER)))
    else $error("winner does not match game over mode");

  a_winner_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (mode == MODE_OVER) |->
      ((winner == PLAYER_SECOND) == (m_axis_tdata_o[25:4] == '0)))
    else $error("wrong winner for remaining times");

  a_reset_menu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[53] |->
      (mode == MODE_MENU) && (player == PLAYER_NONE) && (m_axis_tdata_o[50:48] <= CHOICE_LAST))
    else $error("long press reset did not return to the menu");

endmodule

bind two_player_countdown_clock_unit tpcc_checker u_tpcc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
